FILE: src/rle_pkg.sv
package rle_pkg;

    // Depth of the queue between the classifier and the emitter.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [3:0] BCD_NINE   = 4'd9;

    // Control part of one queued request. The run count and the index of its
    // top nonzero digit travel beside it, since their widths follow the
    // count width.
    typedef struct packed {
        logic       do_close;  // emit the digits of the run count first
        logic       do_sym;    // emit the symbol after any digits
        logic       sat;       // the run count saturated
        logic       last;      // the final byte of this request ends the string
        logic [7:0] sym;
    } rle_entry_ctl_t;

    localparam int CTL_W = $bits(rle_entry_ctl_t);

endpackage

FILE: src/rle_front.sv
module rle_front
    import rle_pkg::*;
#(
    parameter int COUNT_DIGITS = 5
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    sym,
    input  logic                          eos,
    input  logic                          queue_full,
    output logic                          push,
    output rle_entry_ctl_t                entry_ctl,
    output logic [COUNT_DIGITS-1:0][3:0]  entry_count,
    output logic [((COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1)-1:0] entry_top
);

    localparam int IDX_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
    localparam int CW    = 4 * COUNT_DIGITS;

    logic                          in_string_reg, in_string_next;
    logic [7:0]                    prev_reg, prev_next;
    logic [COUNT_DIGITS-1:0][3:0]  count_reg, count_next;
    logic                          ovf_reg, ovf_next;

    logic                          accept;
    logic                          same;
    logic                          lower_nines;
    logic [COUNT_DIGITS-1:0][3:0]  inc_count;
    logic [COUNT_DIGITS-1:0][3:0]  count_bumped;
    logic                          ovf_bumped;
    logic                          run_long;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign same     = in_string_reg && (sym == prev_reg);
    assign run_long = (count_reg != '0) && (count_reg != CW'(1));

    // BCD increment: a digit steps when all digits below it hold nine.
    always_comb
    begin
        lower_nines = 1'b1;
        for (int i = 0; i < COUNT_DIGITS; i++)
        begin
            inc_count[i] = count_reg[i];
            if (lower_nines)
            begin
                inc_count[i] = (count_reg[i] == BCD_NINE) ? 4'd0 : count_reg[i] + 4'd1;
            end
            lower_nines = lower_nines && (count_reg[i] == BCD_NINE);
        end
    end

    // An all-nines count holds and raises the saturation flag.
    assign count_bumped = lower_nines ? count_reg : inc_count;
    assign ovf_bumped   = ovf_reg || lower_nines;

    // Classify the item into at most one request for the emitter.
    always_comb
    begin
        entry_ctl.sym  = sym;
        entry_ctl.last = eos;
        entry_count    = count_reg;
        entry_ctl.sat  = ovf_reg;
        priority if (!in_string_reg)
        begin
            entry_ctl.do_close = 1'b0;
            entry_ctl.do_sym   = 1'b1;
            push               = accept;
        end
        else if (same)
        begin
            entry_ctl.do_close = eos;
            entry_ctl.do_sym   = 1'b0;
            entry_count        = count_bumped;
            entry_ctl.sat      = ovf_bumped;
            push               = accept && eos;
        end
        else
        begin
            entry_ctl.do_close = run_long;
            entry_ctl.do_sym   = 1'b1;
            push               = accept;
        end
    end

    // Index of the most significant nonzero digit of the queued count.
    always_comb
    begin
        entry_top = '0;
        for (int i = 0; i < COUNT_DIGITS; i++)
        begin
            if (entry_count[i] != 4'd0)
            begin
                entry_top = IDX_W'(i);
            end
        end
    end

    // Run state update.
    always_comb
    begin
        in_string_next = in_string_reg;
        prev_next      = prev_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        if (accept)
        begin
            priority if (eos)
            begin
                in_string_next = 1'b0;
                prev_next      = '0;
                count_next     = '0;
                ovf_next       = 1'b0;
            end
            else if (same)
            begin
                count_next = count_bumped;
                ovf_next   = ovf_bumped;
            end
            else
            begin
                in_string_next = 1'b1;
                prev_next      = sym;
                count_next     = CW'(1);
                ovf_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_string_reg <= 1'b0;
            prev_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            in_string_reg <= in_string_next;
            prev_reg      <= prev_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
        end
    end

`ifndef SYNTHESIS
    // An open run always has a count of at least one.
    a_open_run_counted: assert property (@(posedge clk) disable iff (!rst_n)
        in_string_reg |-> (count_reg != '0))
        else $error("open run with a zero count");

    // The final byte of a string closes it.
    a_eos_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eos) |=> !in_string_reg)
        else $error("string still open after its final byte");
`endif

endmodule

FILE: src/rle_queue.sv
module rle_queue
    import rle_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign full    = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign valid   = (fill_reg != '0);
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + (QPTR_W + 1)'(1);
            2'b01:   fill_next = fill_reg - (QPTR_W + 1)'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

`ifndef SYNTHESIS
    // The classifier never writes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("request written into a full queue");

    // The emitter never takes from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("request taken from an empty queue");
`endif

endmodule

FILE: src/rle_back.sv
module rle_back
    import rle_pkg::*;
#(
    parameter int COUNT_DIGITS = 5
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          entry_valid,
    input  rle_entry_ctl_t                entry_ctl,
    input  logic [COUNT_DIGITS-1:0][3:0]  entry_count,
    input  logic [((COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1)-1:0] entry_top,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_data,
    output logic [1:0]                    out_user,
    output logic                          out_last
);

    localparam int IDX_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

    logic                          busy_reg, busy_next;
    logic                          digits_reg, digits_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    rle_entry_ctl_t                ctl_reg, ctl_next;
    logic [COUNT_DIGITS-1:0][3:0]  count_reg, count_next;

    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_data_reg, out_data_next;
    logic [1:0]                    out_user_reg, out_user_next;
    logic                          out_last_reg, out_last_next;

    logic                          out_free;
    logic                          emit;
    logic                          final_byte;
    logic [7:0]                    cur_byte;
    logic                          cur_digit;
    logic                          cur_sat;

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = busy_reg && out_free;

    // Byte of the current request: a count digit or the symbol.
    always_comb
    begin
        if (digits_reg)
        begin
            cur_byte   = ASCII_ZERO + {4'd0, count_reg[idx_reg]};
            cur_digit  = 1'b1;
            cur_sat    = ctl_reg.sat;
            final_byte = (idx_reg == '0) && !ctl_reg.do_sym;
        end
        else
        begin
            cur_byte   = ctl_reg.sym;
            cur_digit  = 1'b0;
            cur_sat    = 1'b0;
            final_byte = 1'b1;
        end
    end

    // The next request loads as the current one hands over its final byte.
    assign pop = entry_valid && (!busy_reg || (emit && final_byte));

    // Request sequencing.
    always_comb
    begin
        busy_next   = busy_reg;
        digits_next = digits_reg;
        idx_next    = idx_reg;
        ctl_next    = ctl_reg;
        count_next  = count_reg;
        if (pop)
        begin
            busy_next   = 1'b1;
            digits_next = entry_ctl.do_close;
            idx_next    = entry_top;
            ctl_next    = entry_ctl;
            count_next  = entry_count;
        end
        else if (emit)
        begin
            if (final_byte)
            begin
                busy_next = 1'b0;
            end
            else if (idx_reg == '0)
            begin
                digits_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - IDX_W'(1);
            end
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = cur_byte;
            out_user_next  = {cur_sat, cur_digit};
            out_last_next  = final_byte && ctl_reg.last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            digits_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            digits_reg    <= digits_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg      <= ctl_next;
        count_reg    <= count_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    // Every queued request produces at least one byte.
    a_request_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (entry_ctl.do_close || entry_ctl.do_sym))
        else $error("empty request taken from the queue");

    // Digits are only sent for a request that closes a run.
    a_digits_need_close: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && digits_reg) |-> ctl_reg.do_close)
        else $error("count digit sent for a request without a run end");
`endif

endmodule

FILE: src/run_length_encoder_top.sv
// Channel  | Signals                      | Contents
// ---------+------------------------------+-------------------------------------------
// s_axis   | tvalid, tready, tdata, tlast | symbol in, tlast marks the final byte
// m_axis   | tvalid, tready, tdata, tuser,| out_byte, count-digit/saturation flags,
//          | tlast                        | tlast on the final byte of the string
//
// The front takes one input byte per cycle while its 4-entry request queue has room.
// The back sends one output byte per cycle while m_axis_tready is high: a request expands
// into up to COUNT_DIGITS count digits, most significant first, then the symbol if any;
// the emitter drives m_axis from a single output register.
// A stalled m_axis holds its byte; the queue fills, then s_axis_tready drops.
// rst_n clears the run state, the queue and the output valid at once.
module run_length_encoder_top
    import rle_pkg::*;
#(
    parameter int COUNT_DIGITS = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic       s_axis_tlast,   // end_of_string
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] is_count_digit, [1] run_saturated
    output logic       m_axis_tlast    // last_of_string
);

    localparam int IDX_W  = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
    localparam int CW     = 4 * COUNT_DIGITS;
    localparam int DATA_W = CTL_W + CW + IDX_W;

    logic                          push;
    logic                          pop;
    logic                          queue_full;
    logic                          queue_valid;
    rle_entry_ctl_t                wr_ctl;
    logic [COUNT_DIGITS-1:0][3:0]  wr_count;
    logic [IDX_W-1:0]              wr_top;
    logic [DATA_W-1:0]             wr_data;
    logic [DATA_W-1:0]             rd_data;
    rle_entry_ctl_t                rd_ctl;
    logic [COUNT_DIGITS-1:0][3:0]  rd_count;
    logic [IDX_W-1:0]              rd_top;

    // Classifier: tracks the run and turns each item into at most one request.
    rle_front #(
        .COUNT_DIGITS (COUNT_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .sym         (s_axis_tdata),
        .eos         (s_axis_tlast),
        .queue_full  (queue_full),
        .push        (push),
        .entry_ctl   (wr_ctl),
        .entry_count (wr_count),
        .entry_top   (wr_top)
    );

    assign wr_data = {wr_ctl, wr_count, wr_top};

    // Request queue between the two sides.
    rle_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_data),
        .full    (queue_full),
        .pop     (pop),
        .valid   (queue_valid),
        .rd_data (rd_data)
    );

    assign {rd_ctl, rd_count, rd_top} = rd_data;

    // Emitter: expands each request into output bytes.
    rle_back #(
        .COUNT_DIGITS (COUNT_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (queue_valid),
        .entry_ctl   (rd_ctl),
        .entry_count (rd_count),
        .entry_top   (rd_top),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_user    (m_axis_tuser),
        .out_last    (m_axis_tlast)
    );

endmodule
